>>> rtl/core/fssr_pkg.sv
// ----------------------------------------------------------------------------
// fssr_pkg
// Shared types and constants of the four-state shift/rotate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fssr_pkg;

	// Amount and port value planes are fixed at 32 bits.
	localparam int AMT_BITS   = 32;
	localparam int VAL_BITS   = 32;

	// Amount reduction: restoring remainder, a fixed number of digits per stage.
	localparam int MOD_STEPS  = 8;
	localparam int MOD_STAGES = AMT_BITS / MOD_STEPS;

	// decode + remainder stages + amount prep + shifter/output register
	localparam int LATENCY    = MOD_STAGES + 3;

	// Operation codes
	localparam logic [2:0] FN_LSL = 3'd0;
	localparam logic [2:0] FN_LSR = 3'd1;
	localparam logic [2:0] FN_ASL = 3'd2;
	localparam logic [2:0] FN_ASR = 3'd3;
	localparam logic [2:0] FN_ROL = 3'd4;
	localparam logic [2:0] FN_ROR = 3'd5;

	typedef struct packed {
		logic [2:0]          func;
		logic [VAL_BITS-1:0] value_aval;
		logic [VAL_BITS-1:0] value_bval;
		logic [5:0]          value_width;
		logic [AMT_BITS-1:0] amount_aval;
		logic [AMT_BITS-1:0] amount_bval;
		logic [5:0]          amount_width;
		logic                amt_signed;
	} req_t;

	typedef struct packed {
		logic [VAL_BITS-1:0] result_aval;
		logic [VAL_BITS-1:0] result_bval;
	} rsp_t;

	// Per-word control decoded in the first stage
	typedef struct packed {
		logic unk;   // amount holds x/z: whole result is x
		logic left;  // direction after sign fix-up
		logic rot;   // rotate rather than shift
		logic fa;    // fill bit, a plane
		logic fb;    // fill bit, b plane
	} ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/fssr_decode.sv
// ----------------------------------------------------------------------------
// fssr_decode
// Stage 1: width clamps, masks, unknown-amount check, sign fix-up, fill bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fssr_decode #(
	parameter  int MAX_WIDTH = 32,
	localparam int WW        = $clog2(MAX_WIDTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     valid,
	input  wire fssr_pkg::req_t           req,
	output      logic                     valid_s1,
	output      fssr_pkg::ctl_t           ctl_s1,
	output      logic [WW-1:0]            w_s1,
	output      logic [MAX_WIDTH-1:0]     m_s1,
	output      logic [MAX_WIDTH-1:0]     va_s1,
	output      logic [MAX_WIDTH-1:0]     vb_s1,
	output      logic [fssr_pkg::AMT_BITS-1:0] amag_s1
);
	import fssr_pkg::*;

	logic [6:0]              wv;
	logic [MAX_WIDTH-1:0]    m;
	logic [MAX_WIDTH+31:0]   va_x;
	logic [MAX_WIDTH+31:0]   vb_x;
	logic [MAX_WIDTH-1:0]    va;
	logic [MAX_WIDTH-1:0]    vb;
	logic [5:0]              aw;
	logic [AMT_BITS-1:0]     am;
	logic [AMT_BITS-1:0]     amag_raw;
	logic [AMT_BITS-1:0]     amag;
	logic                    neg;
	logic [2:0]              fn;
	ctl_t                    ctl;

	always_comb begin
		// value width: zero acts as one, saturate at MAX_WIDTH
		if (req.value_width == 6'd0) begin
			wv = 7'd1;
		end else if ({1'b0, req.value_width} > 7'(MAX_WIDTH)) begin
			wv = 7'(MAX_WIDTH);
		end else begin
			wv = {1'b0, req.value_width};
		end
		m    = {MAX_WIDTH{1'b1}} >> (7'(MAX_WIDTH) - wv);
		va_x = {{MAX_WIDTH{1'b0}}, req.value_aval};
		vb_x = {{MAX_WIDTH{1'b0}}, req.value_bval};
		va   = va_x[MAX_WIDTH-1:0] & m;
		vb   = vb_x[MAX_WIDTH-1:0] & m;

		if (req.amount_width == 6'd0) begin
			aw = 6'd1;
		end else if (req.amount_width > 6'd32) begin
			aw = 6'd32;
		end else begin
			aw = req.amount_width;
		end
		am       = {AMT_BITS{1'b1}} >> (6'd32 - aw);
		amag_raw = req.amount_aval & am;

		fn  = (req.func > FN_ROR) ? FN_LSR : req.func;
		// sign bit is the top bit in use
		neg = req.amt_signed & (|(amag_raw & ~(am >> 1)));
		if (neg) begin
			amag = ({AMT_BITS{1'b0}} - amag_raw) & am;
			fn   = fn ^ 3'd1;
		end else begin
			amag = amag_raw;
		end

		ctl.unk  = |(req.amount_bval & am);
		ctl.left = ~fn[0];
		ctl.rot  = (fn == FN_ROL) || (fn == FN_ROR);
		// top bit in use is va & m & ~(m >> 1)
		if (fn == FN_ASR) begin
			ctl.fa = |(va & ~(m >> 1));
			ctl.fb = |(vb & ~(m >> 1));
		end else if (fn == FN_ASL) begin
			ctl.fa = va[0];
			ctl.fb = vb[0];
		end else begin
			ctl.fa = 1'b0;
			ctl.fb = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1  <= ctl;
		w_s1    <= WW'(wv);
		m_s1    <= m;
		va_s1   <= va;
		vb_s1   <= vb;
		amag_s1 <= amag;
	end

endmodule

`default_nettype wire

>>> rtl/core/fssr_mod_stage.sv
// ----------------------------------------------------------------------------
// fssr_mod_stage
// One remainder stage: MOD_STEPS restoring steps of amount mod width.
// ----------------------------------------------------------------------------
`default_nettype none

module fssr_mod_stage #(
	parameter  int MAX_WIDTH = 32,
	parameter  int STAGE     = 0,
	localparam int WW        = $clog2(MAX_WIDTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid,
	input  wire fssr_pkg::ctl_t                ctl,
	input  wire logic [WW-1:0]                 w,
	input  wire logic [MAX_WIDTH-1:0]          m,
	input  wire logic [MAX_WIDTH-1:0]          va,
	input  wire logic [MAX_WIDTH-1:0]          vb,
	input  wire logic [fssr_pkg::AMT_BITS-1:0] amag,
	input  wire logic [WW-1:0]                 rem,
	input  wire logic                          qnz,
	output      logic                          valid_q,
	output      fssr_pkg::ctl_t                ctl_q,
	output      logic [WW-1:0]                 w_q,
	output      logic [MAX_WIDTH-1:0]          m_q,
	output      logic [MAX_WIDTH-1:0]          va_q,
	output      logic [MAX_WIDTH-1:0]          vb_q,
	output      logic [fssr_pkg::AMT_BITS-1:0] amag_q,
	output      logic [WW-1:0]                 rem_q,
	output      logic                          qnz_q
);
	import fssr_pkg::*;

	// MSB-first: this stage eats amount bits [HI -: MOD_STEPS]
	localparam int HI = AMT_BITS - 1 - STAGE * MOD_STEPS;

	logic [WW-1:0] r;
	logic [WW:0]   t;
	logic          nz;

	always_comb begin
		r  = rem;
		nz = qnz;
		t  = '0;
		for (int j = 0; j < MOD_STEPS; j++) begin
			t = {r, amag[HI - j]};
			if (t >= {1'b0, w}) begin
				t  = t - {1'b0, w};
				nz = 1'b1;  // any quotient bit set means amount >= width
			end
			r = t[WW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		ctl_q  <= ctl;
		w_q    <= w;
		m_q    <= m;
		va_q   <= va;
		vb_q   <= vb;
		amag_q <= amag;
		rem_q  <= r;
		qnz_q  <= nz;
	end

endmodule

`default_nettype wire

>>> rtl/core/fssr_shift.sv
// ----------------------------------------------------------------------------
// fssr_shift
// Amount/fill-mask prep stage, then the barrel shifter into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fssr_shift #(
	parameter  int MAX_WIDTH = 32,
	localparam int WW        = $clog2(MAX_WIDTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid,
	input  wire fssr_pkg::ctl_t                ctl,
	input  wire logic [WW-1:0]                 w,
	input  wire logic [MAX_WIDTH-1:0]          m,
	input  wire logic [MAX_WIDTH-1:0]          va,
	input  wire logic [MAX_WIDTH-1:0]          vb,
	input  wire logic [fssr_pkg::AMT_BITS-1:0] amag,
	input  wire logic [WW-1:0]                 rem,
	input  wire logic                          qnz,
	output      logic                          done,
	output      fssr_pkg::rsp_t                rsp
);
	import fssr_pkg::*;

	// prep stage
	logic                 big;
	logic [WW-1:0]        s;
	logic [WW-1:0]        r;
	logic [WW-1:0]        sl;
	logic [WW-1:0]        sr;
	logic                 en_l;
	logic                 en_r;
	logic [MAX_WIDTH-1:0] fm;

	logic                 valid_s6;
	logic                 unk_s6;
	logic                 fa_s6;
	logic                 fb_s6;
	logic                 en_l_s6;
	logic                 en_r_s6;
	logic [WW-1:0]        sl_s6;
	logic [WW-1:0]        sr_s6;
	logic [MAX_WIDTH-1:0] m_s6;
	logic [MAX_WIDTH-1:0] va_s6;
	logic [MAX_WIDTH-1:0] vb_s6;
	logic [MAX_WIDTH-1:0] fm_s6;

	// shift stage
	logic [MAX_WIDTH-1:0] ra;
	logic [MAX_WIDTH-1:0] rb;
	logic                 valid_s7;
	logic [MAX_WIDTH-1:0] ra_s7;
	logic [MAX_WIDTH-1:0] rb_s7;
	logic [MAX_WIDTH+31:0] ra_x;
	logic [MAX_WIDTH+31:0] rb_x;

	always_comb begin
		big = ~ctl.rot & qnz;
		// below the width the amount equals its remainder
		s   = amag[WW-1:0];
		r   = '0;
		if (ctl.rot) begin
			// right rotate is a left rotate by width - rem
			r    = (ctl.left || rem == '0) ? rem : w - rem;
			sl   = r;
			sr   = w - r;
			en_l = 1'b1;
			en_r = 1'b1;
			fm   = '0;
		end else if (ctl.left) begin
			sl   = s;
			sr   = '0;
			en_l = ~big;
			en_r = 1'b0;
			fm   = big ? m : (m & ~({MAX_WIDTH{1'b1}} << s));
		end else begin
			sl   = '0;
			sr   = s;
			en_l = 1'b0;
			en_r = ~big;
			fm   = big ? m : (m & ~(m >> s));
		end
	end

	always_comb begin
		if (unk_s6) begin
			ra = m_s6;
			rb = m_s6;
		end else begin
			ra = ((en_l_s6 ? (va_s6 << sl_s6) : '0) | (en_r_s6 ? (va_s6 >> sr_s6) : '0)
				| (fa_s6 ? fm_s6 : '0)) & m_s6;
			rb = ((en_l_s6 ? (vb_s6 << sl_s6) : '0) | (en_r_s6 ? (vb_s6 >> sr_s6) : '0)
				| (fb_s6 ? fm_s6 : '0)) & m_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s6 <= valid;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		unk_s6  <= ctl.unk;
		fa_s6   <= ctl.fa;
		fb_s6   <= ctl.fb;
		en_l_s6 <= en_l;
		en_r_s6 <= en_r;
		sl_s6   <= sl;
		sr_s6   <= sr;
		m_s6    <= m;
		va_s6   <= va;
		vb_s6   <= vb;
		fm_s6   <= fm;
		ra_s7   <= ra;
		rb_s7   <= rb;
	end

	assign ra_x = {32'd0, ra_s7};
	assign rb_x = {32'd0, rb_s7};

	assign done            = valid_s7;
	assign rsp.result_aval = ra_x[VAL_BITS-1:0];
	assign rsp.result_bval = rb_x[VAL_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/core/four_state_shift_rotate.sv
// ----------------------------------------------------------------------------
// four_state_shift_rotate
// Pipelined four-state (aval/bval) shifter and rotator.
// ----------------------------------------------------------------------------
// Usage:
//   Command side: drive req and raise start; the word is taken on any clock
//   edge with start high and busy low. busy is always low here, so a new
//   word may be issued every cycle.
//   Result side: done pulses for one cycle with rsp holding the result word.
//   The receiver cannot hold results off, and none is needed: the pipe has
//   no back-pressure and never drops or repeats a word.
//   Throughput: one word per cycle; each word passes the stages below in order.
//   Stages: 1 decode (clamps, masks, sign fix-up), 4 remainder stages
//   (amount mod width, 8 restoring steps each over the 32-bit amount),
//   1 shift-amount / fill-mask prep, 1 barrel shifter into the result register.
//   The remainder chain sets the depth.
//   Reset: arst_n clears all valid bits at once; no word is in flight after.
//   Result bits at and above the value width are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module four_state_shift_rotate #(
	parameter int MAX_WIDTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output      logic           busy,
	input  wire fssr_pkg::req_t req,
	output      logic           done,
	output      fssr_pkg::rsp_t rsp
);
	import fssr_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);

	// stage bus between decode, remainder stages and shifter
	logic                 valid_m [MOD_STAGES+1];
	ctl_t                 ctl_m   [MOD_STAGES+1];
	logic [WW-1:0]        w_m     [MOD_STAGES+1];
	logic [MAX_WIDTH-1:0] m_m     [MOD_STAGES+1];
	logic [MAX_WIDTH-1:0] va_m    [MOD_STAGES+1];
	logic [MAX_WIDTH-1:0] vb_m    [MOD_STAGES+1];
	logic [AMT_BITS-1:0]  amag_m  [MOD_STAGES+1];
	logic [WW-1:0]        rem_m   [MOD_STAGES+1];
	logic                 qnz_m   [MOD_STAGES+1];

	// no back-pressure anywhere in the pipe
	assign busy = 1'b0;

	fssr_decode #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (start && !busy),
		.req      (req),
		.valid_s1 (valid_m[0]),
		.ctl_s1   (ctl_m[0]),
		.w_s1     (w_m[0]),
		.m_s1     (m_m[0]),
		.va_s1    (va_m[0]),
		.vb_s1    (vb_m[0]),
		.amag_s1  (amag_m[0])
	);

	// remainder starts at zero, no quotient bit seen yet
	assign rem_m[0] = '0;
	assign qnz_m[0] = 1'b0;

	for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
		fssr_mod_stage #(
			.MAX_WIDTH (MAX_WIDTH),
			.STAGE     (k)
		) u_mod (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid   (valid_m[k]),
			.ctl     (ctl_m[k]),
			.w       (w_m[k]),
			.m       (m_m[k]),
			.va      (va_m[k]),
			.vb      (vb_m[k]),
			.amag    (amag_m[k]),
			.rem     (rem_m[k]),
			.qnz     (qnz_m[k]),
			.valid_q (valid_m[k+1]),
			.ctl_q   (ctl_m[k+1]),
			.w_q     (w_m[k+1]),
			.m_q     (m_m[k+1]),
			.va_q    (va_m[k+1]),
			.vb_q    (vb_m[k+1]),
			.amag_q  (amag_m[k+1]),
			.rem_q   (rem_m[k+1]),
			.qnz_q   (qnz_m[k+1])
		);
	end

	fssr_shift #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_shift (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_m[MOD_STAGES]),
		.ctl    (ctl_m[MOD_STAGES]),
		.w      (w_m[MOD_STAGES]),
		.m      (m_m[MOD_STAGES]),
		.va     (va_m[MOD_STAGES]),
		.vb     (vb_m[MOD_STAGES]),
		.amag   (amag_m[MOD_STAGES]),
		.rem    (rem_m[MOD_STAGES]),
		.qnz    (qnz_m[MOD_STAGES]),
		.done   (done),
		.rsp    (rsp)
	);

`ifndef NO_ASSERTIONS
	// every accepted word produces a result
	a_issue_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted word produced no result");

	// no result without a matching accepted word
	a_done_has_issue: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching command");

	// an amount fully unknown gives all-x over the used width
	a_unknown_amount: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.amount_bval == 32'hFFFF_FFFF) |-> ##LATENCY
		(done && rsp.result_aval == rsp.result_bval && rsp.result_aval != 32'd0))
		else $error("unknown amount did not give x result");
`endif

endmodule

`default_nettype wire
